### rtl/core/assert_macros.svh
// Assertion macros for the checker file of the core.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/rce_pkg.sv
// Package for the record column extractor: types, constants, serial type sizing.
// No dependencies.
`timescale 1ns / 1ps

package rce_pkg;

    localparam int MAX_COLUMNS  = 16;
    localparam int COUNT_W      = $clog2(MAX_COLUMNS + 1);
    localparam int CFG_COUNT_W  = 5;
    localparam int CFG_TARGET_W = 4;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CMP_W        = (COUNT_W > CFG_COUNT_W) ? COUNT_W : CFG_COUNT_W;
    localparam int LEN_W        = 32;
    localparam int ROWID_W      = 64;
    localparam int VCNT_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLUMN = 1'd1;

    localparam logic [7:0] VARINT_MORE = 8'b1000_0000;
    localparam logic [7:0] VARINT_BITS = 8'b0111_1111;
    localparam logic [VCNT_W-1:0] VARINT_FULL_BYTE = 4'd8;

    localparam logic [63:0] ST_NULL      = 64'd0;
    localparam logic [63:0] ST_INT_MAX   = 64'd4;
    localparam logic [63:0] ST_INT48     = 64'd5;
    localparam logic [63:0] ST_INT64     = 64'd6;
    localparam logic [63:0] ST_FLOAT     = 64'd7;
    localparam logic [63:0] ST_ZERO      = 64'd8;
    localparam logic [63:0] ST_ONE       = 64'd9;
    localparam logic [63:0] ST_RESV_A    = 64'd10;
    localparam logic [63:0] ST_RESV_B    = 64'd11;
    localparam logic [63:0] ST_BLOB_BASE = 64'd12;
    localparam logic [LEN_W-1:0] SIZE_INT48 = 32'd6;
    localparam logic [LEN_W-1:0] SIZE_8BYTE = 32'd8;

    typedef enum logic [5:0] {
        PH_WAIT    = 6'b000001,
        PH_RECSIZE = 6'b000010,
        PH_ROWID   = 6'b000100,
        PH_HDRSIZE = 6'b001000,
        PH_TYPES   = 6'b010000,
        PH_BODY    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0]         value_byte;
        logic               value_last;
        logic               empty_value;
        logic               bad_type;
        logic [ROWID_W-1:0] row_id;
    } t_result;

    function automatic logic [LEN_W-1:0] type_size(input logic [63:0] t);
        logic [62:0]      d;
        logic [LEN_W-1:0] s;
        d = t[63:1] - 63'(ST_BLOB_BASE >> 1);
        if (t == ST_NULL || t == ST_ZERO || t == ST_ONE) begin
            s = '0;
        end else if (t <= ST_INT_MAX) begin
            s = t[LEN_W-1:0];
        end else if (t == ST_INT48) begin
            s = SIZE_INT48;
        end else if (t == ST_INT64 || t == ST_FLOAT) begin
            s = SIZE_8BYTE;
        end else begin
            s = (|d[62:LEN_W]) ? '1 : d[LEN_W-1:0];
        end
        return s;
    endfunction

endpackage

### rtl/core/rce_parser.sv
// Cell parser: varint decode, serial type sizing and body byte selection.
// Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_parser import rce_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_cell_start,
    input  logic [CFG_COUNT_W-1:0]  i_column_count,
    input  logic [CFG_TARGET_W-1:0] i_target_column,
    input  logic                    i_out_free,
    output logic                    o_advance,
    output logic                    o_load,
    output t_result                 o_result
);

    t_phase               r_phase, n_phase, cur_phase;
    logic [63:0]          r_varint, n_varint, cur_varint, feed_val;
    logic [VCNT_W-1:0]    r_vcount, n_vcount, cur_vcount;
    logic [COUNT_W-1:0]   r_cols, n_cols, cur_cols, cols_after;
    logic [LEN_W-1:0]     r_bb, n_bb, cur_bb;
    logic [LEN_W-1:0]     r_tl, n_tl, cur_tl, tl_after, tsize;
    logic [LEN_W-1:0]     r_pos, n_pos, cur_pos;
    logic [ROWID_W-1:0]   r_row, n_row, cur_row;
    logic                 feed_done, is_ninth, is_bad, emit;
    logic [LEN_W:0]       bb_sum, body_end, pos_ext;
    logic [CMP_W-1:0]     eff_count, cc_ext, target_ext;
    logic                 target_ok;

    always_comb begin
        cur_phase  = i_cell_start ? PH_RECSIZE : r_phase;
        cur_varint = i_cell_start ? '0 : r_varint;
        cur_vcount = i_cell_start ? '0 : r_vcount;
        cur_cols   = i_cell_start ? '0 : r_cols;
        cur_bb     = i_cell_start ? '0 : r_bb;
        cur_tl     = i_cell_start ? '0 : r_tl;
        cur_pos    = i_cell_start ? '0 : r_pos;
        cur_row    = i_cell_start ? '0 : r_row;

        is_ninth  = (cur_vcount == VARINT_FULL_BYTE);
        feed_val  = is_ninth ? {cur_varint[55:0], i_data_byte}
                             : {cur_varint[56:0], i_data_byte[6:0] & VARINT_BITS[6:0]};
        feed_done = is_ninth || ((i_data_byte & VARINT_MORE) == 8'd0);

        cc_ext     = CMP_W'(i_column_count);
        eff_count  = (cc_ext > CMP_W'(MAX_COLUMNS)) ? CMP_W'(MAX_COLUMNS) : cc_ext;
        target_ext = CMP_W'(i_target_column);
        target_ok  = target_ext < eff_count;

        tsize      = type_size(feed_val);
        is_bad     = (feed_val == ST_RESV_A) || (feed_val == ST_RESV_B);
        bb_sum     = {1'b0, cur_bb} + {1'b0, tsize};
        tl_after   = (CMP_W'(cur_cols) == target_ext) ? tsize : cur_tl;
        cols_after = cur_cols + COUNT_W'(1);

        body_end   = {1'b0, cur_bb} + {1'b0, cur_tl};
        pos_ext    = {1'b0, cur_pos};
    end

    always_comb begin
        n_phase  = cur_phase;
        n_varint = cur_varint;
        n_vcount = cur_vcount;
        n_cols   = cur_cols;
        n_bb     = cur_bb;
        n_tl     = cur_tl;
        n_pos    = cur_pos;
        n_row    = cur_row;
        emit     = 1'b0;
        o_result = '{value_byte: 8'd0, value_last: 1'b0, empty_value: 1'b0,
                     bad_type: 1'b0, row_id: cur_row};

        if (cur_phase inside {PH_RECSIZE, PH_ROWID, PH_HDRSIZE, PH_TYPES}) begin
            n_varint = feed_done ? '0 : feed_val;
            n_vcount = feed_done ? '0 : cur_vcount + VCNT_W'(1);
        end

        case (cur_phase)
            PH_RECSIZE: begin
                if (feed_done) n_phase = PH_ROWID;
            end
            PH_ROWID: begin
                if (feed_done) begin
                    n_row   = feed_val;
                    n_phase = PH_HDRSIZE;
                end
            end
            PH_HDRSIZE: begin
                if (feed_done) begin
                    n_phase = (CMP_W'(cur_cols) >= eff_count) ? PH_WAIT : PH_TYPES;
                end
            end
            PH_TYPES: begin
                if (feed_done) begin
                    if (is_bad) begin
                        n_phase                 = PH_WAIT;
                        emit                    = 1'b1;
                        o_result.value_last     = 1'b1;
                        o_result.bad_type       = 1'b1;
                    end else begin
                        if (CMP_W'(cur_cols) < target_ext) begin
                            n_bb = bb_sum[LEN_W] ? '1 : bb_sum[LEN_W-1:0];
                        end
                        n_tl   = tl_after;
                        n_cols = cols_after;
                        if (CMP_W'(cols_after) >= eff_count) begin
                            if (target_ok && tl_after == '0) begin
                                n_phase              = PH_WAIT;
                                emit                 = 1'b1;
                                o_result.value_last  = 1'b1;
                                o_result.empty_value = 1'b1;
                            end else if (target_ok) begin
                                n_phase = PH_BODY;
                                n_pos   = '0;
                            end else begin
                                n_phase = PH_WAIT;
                            end
                        end
                    end
                end
            end
            PH_BODY: begin
                n_pos = (cur_pos != '1) ? cur_pos + LEN_W'(1) : cur_pos;
                if (pos_ext >= {1'b0, cur_bb} && pos_ext < body_end) begin
                    emit                = 1'b1;
                    o_result.value_byte = i_data_byte;
                    if (pos_ext + (LEN_W+1)'(1) == body_end) begin
                        o_result.value_last = 1'b1;
                        n_phase             = PH_WAIT;
                    end
                end
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    assign o_advance = i_valid && (i_out_free || !emit);
    assign o_load    = o_advance && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_varint <= '0;
            r_vcount <= '0;
            r_cols   <= '0;
            r_bb     <= '0;
            r_tl     <= '0;
            r_pos    <= '0;
            r_row    <= '0;
        end else if (o_advance) begin
            r_phase  <= n_phase;
            r_varint <= n_varint;
            r_vcount <= n_vcount;
            r_cols   <= n_cols;
            r_bb     <= n_bb;
            r_tl     <= n_tl;
            r_pos    <= n_pos;
            r_row    <= n_row;
        end
    end

endmodule

### rtl/core/rce_out_buf.sv
// Result register: holds one result transaction until the receiver takes it.
// Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_out_buf import rce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign n_valid  = i_load || (r_valid && i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/core/record_column_extractor_core.sv
// Top level of the record column extractor: input register, parser, result register.
// Depends on rce_pkg, rce_parser and rce_out_buf.
`timescale 1ns / 1ps

// Streams the bytes of one table-leaf cell, one byte per transaction, and returns
// the bytes of the column chosen by target_column together with the decoded row id.
// One byte is taken every cycle while the input does not stall; each result passes
// through the input register and the result register: the byte sits in the input
// register while the single parse stage works on it, and the result register then
// presents the outcome. The input stalls only while a finished result waits and
// the held byte would produce another. A reserved serial type gives one result with
// bad_type set and drops the rest of the cell; an empty column gives one result
// with empty_value set. Write configuration only while the block is idle.
module record_column_extractor_core import rce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_cell_start,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_value_byte,
    output logic                   o_value_last,
    output logic                   o_empty_value,
    output logic                   o_bad_type,
    output logic [ROWID_W-1:0]     o_row_id
);

    logic                    r_in_valid, n_in_valid;
    logic [7:0]              r_data_byte;
    logic                    r_cell_start;
    logic [CFG_COUNT_W-1:0]  r_column_count;
    logic [CFG_TARGET_W-1:0] r_target_column;
    logic                    in_accept, advance, load, out_free;
    t_result                 parse_result, out_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign n_in_valid  = in_accept || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_column_count  <= CFG_COUNT_W'(1);
            r_target_column <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_COLUMN_COUNT:  r_column_count  <= i_cfg_data[CFG_COUNT_W-1:0];
                    REG_TARGET_COLUMN: r_target_column <= i_cfg_data[CFG_TARGET_W-1:0];
                    default:           r_target_column <= r_target_column;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data_byte  <= i_data_byte;
            r_cell_start <= i_cell_start;
        end
    end

    rce_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_data_byte     (r_data_byte),
        .i_cell_start    (r_cell_start),
        .i_column_count  (r_column_count),
        .i_target_column (r_target_column),
        .i_out_free      (out_free),
        .o_advance       (advance),
        .o_load          (load),
        .o_result        (parse_result)
    );

    rce_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (parse_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_value_byte  = out_result.value_byte;
    assign o_value_last  = out_result.value_last;
    assign o_empty_value = out_result.empty_value;
    assign o_bad_type    = out_result.bad_type;
    assign o_row_id      = out_result.row_id;

endmodule

### rtl/core/rce_checker.sv
// Port checker for the record column extractor, bound to the top level.
// Depends on rce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rce_checker import rce_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [7:0]             o_value_byte,
    input logic                   o_value_last,
    input logic                   o_empty_value,
    input logic                   o_bad_type,
    input logic [ROWID_W-1:0]     o_row_id
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_value_byte) && $stable(o_row_id) && $stable(o_value_last))
    `ASSERT_IMPLY(a_bad_shape, i_clk, i_rst_n, o_out_valid && o_bad_type, o_value_last && !o_empty_value && o_value_byte == 8'd0)
    `ASSERT_IMPLY(a_empty_shape, i_clk, i_rst_n, o_out_valid && o_empty_value, o_value_last && !o_bad_type && o_value_byte == 8'd0)
    `ASSERT_IMPLY(a_no_idle_stall, i_clk, i_rst_n, !i_out_stall, !o_in_stall)

endmodule

bind record_column_extractor_core rce_checker u_rce_checker (.*);
